// ===== src/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the sensor frame deframer
// Frame layout, status codes and the result item structure.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // frame geometry
  localparam int FRAME_BYTES = 9;
  localparam int POS_W       = 4;
  localparam int HUNT_W      = 7;

  localparam logic [POS_W-1:0]  POS_HUNT  = POS_W'(0);
  localparam logic [POS_W-1:0]  POS_TYPE  = POS_W'(1);
  localparam logic [POS_W-1:0]  POS_CHECK = POS_W'(FRAME_BYTES - 1);
  localparam logic [HUNT_W-1:0] MAX_HUNT  = HUNT_W'(64);

  // byte codes
  localparam logic [7:0] START_BYTE    = 8'hFF;
  localparam logic [7:0] TYPE_RESPONSE = 8'h86;
  localparam logic [7:0] TYPE_ACTIVE   = 8'h3B;

  // value byte offsets per mode (high byte of first concentration)
  localparam logic [POS_W-1:0] BASE_RESPONSE = POS_W'(2);
  localparam logic [POS_W-1:0] BASE_ACTIVE   = POS_W'(4);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_TYPE  = 2'd1,
    ST_BAD_SUM   = 2'd2,
    ST_SYNC_LOST = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] avg_four_hour;
    logic [15:0] avg_day;
  } result_t;

endpackage

// ===== src/sensor_frame_deframer.sv =====
// A result is loaded into the result register when the byte that closes it moves on from the byte register.
// Bytes enter at one per cycle while no result is stalled; the byte register and result register each hold one item.
// A stalled result holds the byte register too, so at most two items are in flight.
// Reset (synchronous, rst_n low): hunting for start, counters cleared, frame_mode 0.
// ----------------------------------------------------------------------------
// sensor_frame_deframer: top level
// Deframes nine-byte sensor frames, checks type and checksum, reports values or sync loss while hunting.
// ----------------------------------------------------------------------------
module sensor_frame_deframer
  import sfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_frame_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_avg_four_hour,
  output logic [15:0] out_avg_day
);

  logic       frame_mode_r;
  logic       byte_valid;
  logic [7:0] byte_data;
  logic       can_load;
  logic       byte_go;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // mode register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      frame_mode_r <= cfg_frame_mode;
    end
  end

  // held byte moves on whenever the result register can take a load
  assign byte_go = byte_valid && can_load;

  sfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (byte_go),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  sfd_frame_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_go    (byte_go),
    .byte_data  (byte_data),
    .frame_mode (frame_mode_r),
    .res_valid  (res_valid),
    .res        (res)
  );

  sfd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status        = out_res.status;
  assign out_avg_four_hour = out_res.avg_four_hour;
  assign out_avg_day       = out_res.avg_day;

endmodule

// ===== src/sfd_in_stage.sv =====
// ----------------------------------------------------------------------------
// sfd_in_stage: input register
// Holds one received byte until the frame core consumes it.
// ----------------------------------------------------------------------------
module sfd_in_stage
  import sfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,        // core consumes the held byte
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic [7:0] data_r;

  // free slot, or the held item leaves this cycle
  assign in_ready   = !valid_r || take;
  assign byte_valid = valid_r;
  assign byte_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_rx_byte;
    end
  end

endmodule

// ===== src/sfd_frame_core.sv =====
// ----------------------------------------------------------------------------
// sfd_frame_core: frame tracking state and per-byte decode
// Hunts for the start byte, tracks position, sum, type match and values.
// ----------------------------------------------------------------------------
module sfd_frame_core
  import sfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_go,     // process byte_data this cycle
  input  logic [7:0] byte_data,
  input  logic       frame_mode,
  output logic       res_valid,
  output result_t    res
);

  logic [POS_W-1:0]  pos_r,    pos_nxt;
  logic [7:0]        sum_r,    sum_nxt;
  logic              type_r,   type_nxt;
  logic [15:0]       first_r,  first_nxt;
  logic [15:0]       second_r, second_nxt;
  logic [HUNT_W-1:0] hunt_r,   hunt_nxt;

  logic [HUNT_W-1:0] hunt_inc;
  logic [7:0]        sum_expect;
  logic [7:0]        type_want;
  logic [POS_W-1:0]  base;
  logic              hit;

  assign hunt_inc   = hunt_r + HUNT_W'(1);
  assign sum_expect = 8'd0 - sum_r;
  assign type_want  = frame_mode ? TYPE_ACTIVE : TYPE_RESPONSE;
  assign base       = frame_mode ? BASE_ACTIVE : BASE_RESPONSE;

  // next state and result for the current byte
  always_comb begin
    pos_nxt    = pos_r;
    sum_nxt    = sum_r;
    type_nxt   = type_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    hunt_nxt   = hunt_r;
    hit        = 1'b0;
    res        = '{status: ST_OK, avg_four_hour: 16'd0, avg_day: 16'd0};

    if (pos_r == POS_HUNT) begin
      if (byte_data == START_BYTE) begin
        pos_nxt    = POS_TYPE;
        sum_nxt    = 8'd0;
        type_nxt   = 1'b0;
        first_nxt  = 16'd0;
        second_nxt = 16'd0;
        hunt_nxt   = '0;
      end else if (hunt_inc >= MAX_HUNT) begin
        hunt_nxt   = '0;
        hit        = 1'b1;
        res.status = ST_SYNC_LOST;
      end else begin
        hunt_nxt = hunt_inc;
      end
    end else if (pos_r >= POS_CHECK) begin
      // checksum byte closes the frame
      pos_nxt  = POS_HUNT;
      hunt_nxt = '0;
      hit      = 1'b1;
      if (!type_r) begin
        res.status = ST_BAD_TYPE;
      end else if (byte_data != sum_expect) begin
        res.status = ST_BAD_SUM;
      end else begin
        res.status        = ST_OK;
        res.avg_four_hour = first_r;
        res.avg_day       = second_r;
      end
    end else begin
      if (pos_r == POS_TYPE) begin
        type_nxt = (byte_data == type_want);
      end else if (pos_r == base) begin
        first_nxt[15:8] = byte_data;
      end else if (pos_r == base + POS_W'(1)) begin
        first_nxt[7:0] = byte_data;
      end else if (pos_r == base + POS_W'(2)) begin
        second_nxt[15:8] = byte_data;
      end else if (pos_r == base + POS_W'(3)) begin
        second_nxt[7:0] = byte_data;
      end
      sum_nxt = sum_r + byte_data;
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  assign res_valid = byte_go && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= POS_HUNT;
      sum_r    <= 8'd0;
      type_r   <= 1'b0;
      first_r  <= 16'd0;
      second_r <= 16'd0;
      hunt_r   <= '0;
    end else if (byte_go) begin
      pos_r    <= pos_nxt;
      sum_r    <= sum_nxt;
      type_r   <= type_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      hunt_r   <= hunt_nxt;
    end
  end

endmodule

// ===== src/sfd_out_stage.sv =====
// ----------------------------------------------------------------------------
// sfd_out_stage: result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module sfd_out_stage
  import sfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res,
  output logic    can_load,   // register free or emptied this cycle
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r;
  result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && res_valid) begin
      res_r <= res;
    end
  end

endmodule

// ===== src/sfd_checker.sv =====
// ----------------------------------------------------------------------------
// sfd_checker: port-level assertions for the deframer
// Checks result payload rules, stall behavior and reset on the top ports.
// ----------------------------------------------------------------------------
module sfd_checker
  import sfd_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_avg_four_hour,
  input logic [15:0] out_avg_day
);

  // failed frames and sync loss carry zero values
  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_avg_four_hour == 16'd0) && (out_avg_day == 16'd0))
    else $error("nonzero values on a failed result");

  // input side only stalls behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while result path free");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_avg_four_hour) && $stable(out_avg_day))
    else $error("stalled result changed");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (.*);
